// ----- hdl/tpfd_pkg.sv -----
// Shared types and constants for the texture pixel format decoder.
package tpfd_pkg;

    // Pixel format codes held in the format register
    localparam logic [2:0] FMT_A8        = 3'd0;
    localparam logic [2:0] FMT_R8        = 3'd1;
    localparam logic [2:0] FMT_R16       = 3'd2;
    localparam logic [2:0] FMT_RGB565    = 3'd3;
    localparam logic [2:0] FMT_R_HALF    = 3'd4;
    localparam logic [2:0] FMT_RG_HALF   = 3'd5;
    localparam logic [2:0] FMT_RGBA_HALF = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] CFG_BIG_ENDIAN   = 2'd1;

    // Channel counts reported per pixel
    localparam logic [2:0] CNT_RGB  = 3'd3;
    localparam logic [2:0] CNT_RGBA = 3'd4;

    // Half-float limits
    localparam logic [4:0] HALF_EXP_INF = 5'd31;
    localparam logic [4:0] HALF_EXP_ONE = 5'd15;
    localparam logic [7:0] UNORM_MAX    = 8'd255;

    // Number of half lanes (one per input word)
    localparam int LANES = 4;

    typedef struct packed {
        logic [15:0] word0;
        logic [15:0] word1;
        logic [15:0] word2;
        logic [15:0] word3;
        logic        last_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [2:0] channel_count;
        logic       last_out;
    } tex_out_t;

    // Control carried alongside the lane stage
    typedef struct packed {
        logic        valid;
        logic        last;
        logic [2:0]  fmt;
        logic        big_endian;
        logic [15:0] word0;
    } tpfd_ctl_t;

endpackage

// ----- hdl/tpfd_half_lane.sv -----
// One half-float to unorm8 conversion lane, two stages.
module tpfd_half_lane
    import tpfd_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  logic [15:0] word,
    input  logic        big_endian,
    output logic [7:0]  value
);

    logic [15:0] half;
    logic        sign;
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [10:0] sig;
    logic        zero_next;
    logic        sat_next;
    logic [18:0] prod_next;
    logic [4:0]  sh_next;

    logic        zero_reg;
    logic        sat_reg;
    logic [18:0] prod_reg;
    logic [4:0]  sh_reg;

    logic [24:0] sum;
    logic [24:0] shifted;

    // Stage 1: byte order, classify, significand times 255
    always_comb
    begin
        half      = big_endian ? {word[7:0], word[15:8]} : word;
        sign      = half[15];
        ex        = half[14:10];
        man       = half[9:0];
        zero_next = (ex == HALF_EXP_INF) || sign;
        sat_next  = !zero_next &&
                    ((ex > HALF_EXP_ONE) || ((ex == HALF_EXP_ONE) && (man != 10'd0)));
        sig       = (ex == 5'd0) ? {1'b0, man} : {1'b1, man};
        prod_next = ({8'd0, sig} << 8) - {8'd0, sig};
        sh_next   = (ex == 5'd0) ? 5'd24 : (5'd25 - ex);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            zero_reg <= zero_next;
            sat_reg  <= sat_next;
            prod_reg <= prod_next;
            sh_reg   <= sh_next;
        end
    end

    // Stage 2: round half up, shift down, clamp
    always_comb
    begin
        sum     = {6'd0, prod_reg} + (25'd1 << (sh_reg - 5'd1));
        shifted = sum >> sh_reg;
        if (zero_reg)
            value = 8'd0;
        else if (sat_reg)
            value = UNORM_MAX;
        else
            value = shifted[7:0];
    end

endmodule

// ----- hdl/tpfd_merge.sv -----
// Merge stage: picks channels per format and registers the result.
module tpfd_merge
    import tpfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tpfd_ctl_t  ctl,
    input  logic [7:0] lane_val [LANES],
    output logic       done,
    output tex_out_t   texel
);

    logic [15:0] v565;
    logic [4:0]  r5;
    logic [5:0]  g6;
    logic [4:0]  b5;
    tex_out_t    texel_next;
    tex_out_t    texel_reg;
    logic        done_reg;

    // Channel selection
    always_comb
    begin
        v565 = ctl.big_endian ? {ctl.word0[7:0], ctl.word0[15:8]} : ctl.word0;
        r5   = v565[15:11];
        g6   = v565[10:5];
        b5   = v565[4:0];

        texel_next               = '0;
        texel_next.channel_count = CNT_RGB;
        texel_next.last_out      = ctl.last;
        unique case (ctl.fmt)
            FMT_A8:
            begin
                texel_next.red   = ctl.word0[7:0];
                texel_next.green = ctl.word0[7:0];
                texel_next.blue  = ctl.word0[7:0];
            end
            FMT_R8:
                texel_next.red = ctl.word0[7:0];
            FMT_R16:
                texel_next.red = ctl.big_endian ? ctl.word0[7:0] : ctl.word0[15:8];
            FMT_RGB565:
            begin
                texel_next.red   = {r5, r5[4:2]};
                texel_next.green = {g6, g6[5:4]};
                texel_next.blue  = {b5, b5[4:2]};
            end
            FMT_R_HALF:
                texel_next.red = lane_val[0];
            FMT_RG_HALF:
            begin
                texel_next.red   = lane_val[0];
                texel_next.green = lane_val[1];
            end
            FMT_RGBA_HALF:
            begin
                texel_next.red           = lane_val[0];
                texel_next.green         = lane_val[1];
                texel_next.blue          = lane_val[2];
                texel_next.alpha         = lane_val[3];
                texel_next.channel_count = CNT_RGBA;
            end
            default:
            begin
                // undefined code: all channels stay zero
            end
        endcase
    end

    // Result register and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
            texel_reg <= texel_next;
    end

    assign done  = done_reg;
    assign texel = texel_reg;

endmodule

// ----- hdl/texture_pixel_format_decoder_top.sv -----
// Top level of the texture pixel format decoder.
//
// Usage:
//   Pixel channel: drive pixel and pulse start; a pixel transfers at each
//   edge with start high and busy low. busy stays low, so one pixel can be
//   taken every cycle.
//   Result channel: done is high for one cycle with the decoded texel on
//   texel after the lane and result registers. Results leave in order.
//   The receiver cannot hold results off; one result per pixel.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index 0 selects
//   pixel_format, 1 selects big_endian; other indexes are dropped.
//   cfg_ready is always high. Write only with no pixels in flight.
//   Throughput 1 pixel per cycle: stage one feeds four half lanes (swap,
//   classify, multiply by 255), stage two rounds in the
//   lanes and the merge stage selects channels into the result register.
//   Reset clears both config registers (format A8, little endian) and the
//   in-flight valid bits; no result is shown until a pixel is taken.
module texture_pixel_format_decoder_top
    import tpfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  pix_in_t    pixel,
    output logic       done,
    output tex_out_t   texel,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [2:0] cfg_data
);

    logic        accept;
    logic [2:0]  fmt_reg;
    logic        be_reg;
    tpfd_ctl_t   ctl_reg;
    tpfd_ctl_t   ctl_next;
    logic [15:0] lane_word [LANES];
    logic [7:0]  lane_val  [LANES];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_A8;
            be_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PIXEL_FORMAT: fmt_reg <= cfg_data;
                CFG_BIG_ENDIAN:   be_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Control stage beside the lanes
    always_comb
    begin
        ctl_next            = ctl_reg;
        ctl_next.valid      = accept;
        if (accept)
        begin
            ctl_next.last       = pixel.last_in;
            ctl_next.fmt        = fmt_reg;
            ctl_next.big_endian = be_reg;
            ctl_next.word0      = pixel.word0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_next;
    end

    // Half-float lanes, one per word
    assign lane_word[0] = pixel.word0;
    assign lane_word[1] = pixel.word1;
    assign lane_word[2] = pixel.word2;
    assign lane_word[3] = pixel.word3;

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        tpfd_half_lane u_lane (
            .clk        (clk),
            .load       (accept),
            .word       (lane_word[i]),
            .big_endian (be_reg),
            .value      (lane_val[i])
        );
    end

    tpfd_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_reg),
        .lane_val (lane_val),
        .done     (done),
        .texel    (texel)
    );

endmodule

// ----- hdl/tpfd_checker.sv -----
// Port-level checker for the texture pixel format decoder, with its bind.
module tpfd_checker
    import tpfd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input pix_in_t  pixel,
    input logic     done,
    input tex_out_t texel
);

    // Every transfer yields a result once past the lane and result registers
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("pixel transfer without result");

    // No result without a matching earlier transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without pixel transfer");

    // Last marker travels with its pixel
    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (texel.last_out == $past(pixel.last_in, 2)))
        else $error("last marker mismatch");

    // Channel count is three with alpha zero, or four
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((texel.channel_count == CNT_RGB && texel.alpha == 8'd0) ||
                  texel.channel_count == CNT_RGBA))
        else $error("bad channel count or stray alpha");

endmodule

bind texture_pixel_format_decoder_top tpfd_checker u_tpfd_checker (.*);
